>>> hw/rtl/cse_pkg.sv
// Shared types and constants of the cosine similarity engine.
package cse_pkg;

    // Accumulator width: room for 4096 full-scale Q2.30 products
    localparam int unsigned ACC_W      = 43;
    // Root of a 64-bit radicand, two radicand bits per step
    localparam int unsigned RAD_W      = 64;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned SQRT_STEPS = 32;
    // Product of the two roots and fraction bits of the quotient
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned QUO_W      = 36;
    localparam int unsigned DIV_STEPS  = 36;

    // Handshake status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

>>> hw/rtl/cse_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module cse_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cse_pkg::RAD_W-1:0]    radicand,
    output logic [cse_pkg::ROOT_W-1:0]   root,
    output cse_pkg::unit_status_t        status
);
    import cse_pkg::*;

    localparam int unsigned REM_W = ROOT_W + 2;
    localparam int unsigned CNT_W = $clog2(SQRT_STEPS);

    logic [RAD_W-1:0]  rad_reg,   rad_next;
    logic [REM_W-1:0]  rem_reg,   rem_next;
    logic [ROOT_W-1:0] root_reg,  root_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;

    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              fits;

    assign shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign fits    = (shifted >= trial);

    always_comb begin
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rad_next   = radicand;
            rem_next   = '0;
            root_next  = '0;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rad_next   = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next   = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_next  = {root_reg[ROOT_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(SQRT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> hw/rtl/cse_div.sv
// Restoring fraction divider: quotient bits of dividend / divisor, one per cycle.
module cse_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cse_pkg::ACC_W-1:0]    dividend,
    input  logic [cse_pkg::PROD_W-1:0]   divisor,
    output logic [cse_pkg::QUO_W-1:0]    quotient,
    output logic                         over,
    output cse_pkg::unit_status_t        status
);
    import cse_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic [PROD_W-1:0] rem_reg,   rem_next;
    logic [PROD_W-1:0] dvs_reg,   dvs_next;
    logic [QUO_W-1:0]  quo_reg,   quo_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              over_reg,  over_next;
    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;

    logic [PROD_W:0]   shifted;
    logic [PROD_W:0]   diff;
    logic              fits;
    logic              whole;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});
    // A ratio of one or more saturates: skip the fraction steps
    assign whole   = ({{(PROD_W-ACC_W){1'b0}}, dividend} >= divisor);

    always_comb begin
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        over_next  = over_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = {{(PROD_W-ACC_W){1'b0}}, dividend};
            dvs_next   = divisor;
            quo_next   = '0;
            count_next = '0;
            over_next  = whole;
            busy_next  = !whole;
            done_next  = whole;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
            quo_next   = {quo_reg[QUO_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        over_reg <= over_next;
    end

    assign quotient    = quo_reg;
    assign over        = over_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> hw/rtl/cosine_similarity_engine.sv
// Cosine similarity engine: streaming dot product and norms, then a Q1.15 cosine per vector pair.
//
// Each input word carries one element of vector A and one of vector B (both signed Q1.15);
// tlast marks the final pair. The block keeps a 43-bit saturating dot product and two
// saturating sums of squares, sized for vectors of up to 4096 pairs. On the last pair it
// takes both roots (each with 10 fraction bits), multiplies them and divides |dot| by that
// product to 36 fraction bits, rounds half away from zero and emits the cosine in signed
// Q1.15, clamped to 32767 above and -32768 below. If either sum of squares is zero the
// word carries similarity 0 and zero_norm set. The accumulators then clear for the next
// vector. One multiplier is shared by all products, one root unit by both norms.
// Sequence: an ordinary word is accepted, then passes three multiply/accumulate steps and
// a final add. A last word with non-zero norms then runs the two 32-step roots and the
// 36-step divider; a last word with a zero norm goes straight to the result. The result
// sits in an output register, so the next vector may start streaming while the previous
// result waits to be taken. s_tready is high only while the sequencer is idle.
module cosine_similarity_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave side: feature_a [15:0], feature_b [31:16]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,    // last_element
    // Master side: similarity [15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [0:0]  m_tuser     // zero_norm [0]
);
    import cse_pkg::*;

    localparam int unsigned SUM_W = ACC_W + 2;
    localparam logic signed [SUM_W-1:0] DOT_MAX = SUM_W'((64'sd1 <<< (ACC_W-1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] DOT_MIN = SUM_W'(-(64'sd1 <<< (ACC_W-1)));
    localparam logic signed [SUM_W-1:0] SQ_MAX  = SUM_W'((64'sd1 <<< ACC_W) - 64'sd1);
    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_MUL_AB    = 11'b000_0000_0010,
        ST_MUL_AA    = 11'b000_0000_0100,
        ST_MUL_BB    = 11'b000_0000_1000,
        ST_ADD_BB    = 11'b000_0001_0000,
        ST_CHECK     = 11'b000_0010_0000,
        ST_SQRT_A    = 11'b000_0100_0000,
        ST_SQRT_B    = 11'b000_1000_0000,
        ST_DIV_START = 11'b001_0000_0000,
        ST_DIV_WAIT  = 11'b010_0000_0000,
        ST_EMIT      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Latched word
    logic signed [15:0] a_reg, a_next;
    logic signed [15:0] b_reg, b_next;
    logic               last_reg, last_next;

    // Accumulators
    logic signed [ACC_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0]        sqa_reg, sqa_next;
    logic [ACC_W-1:0]        sqb_reg, sqb_next;

    // Shared multiplier and its output register
    logic signed [32:0]       mul_x, mul_y;
    logic signed [65:0]       mul_p;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [ROOT_W-1:0]        ra_reg, ra_next;

    // Shared saturating adder
    logic signed [SUM_W-1:0]  add_acc, add_term, add_sum;
    logic signed [ACC_W-1:0]  dot_sat;
    logic [ACC_W-1:0]         sq_sat;

    // Result holding and output register
    logic signed [15:0] res_sim_reg, res_sim_next;
    logic               res_zero_reg, res_zero_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    // Arithmetic units
    logic                 sqrt_start;
    logic [RAD_W-1:0]     sqrt_rad;
    logic [ROOT_W-1:0]    sqrt_root;
    unit_status_t         sqrt_stat;
    logic                 div_start;
    logic [ACC_W-1:0]     dot_mag;
    logic [QUO_W-1:0]     div_quo;
    logic                 div_over;
    unit_status_t         div_stat;

    logic                 in_fire;
    logic                 out_free;
    logic                 zero_case;
    logic [QUO_W:0]       rnd_sum;
    logic [QUO_W-1:0]     mag_rnd;
    logic signed [15:0]   sim_val;

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign zero_case = (sqa_reg == '0) || (sqb_reg == '0);

    // Shared multiplier: element products, then the product of the two roots
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            ST_MUL_AB: begin
                mul_x = 33'(a_reg);
                mul_y = 33'(b_reg);
            end
            ST_MUL_AA: begin
                mul_x = 33'(a_reg);
                mul_y = 33'(a_reg);
            end
            ST_MUL_BB: begin
                mul_x = 33'(b_reg);
                mul_y = 33'(b_reg);
            end
            ST_SQRT_B: begin
                mul_x = signed'({1'b0, ra_reg});
                mul_y = signed'({1'b0, sqrt_root});
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // Shared adder: one accumulator per step, fed by the registered product
    always_comb begin
        add_acc = '0;
        unique case (state_reg)
            ST_MUL_AA: add_acc = SUM_W'(dot_reg);
            ST_MUL_BB: add_acc = signed'({2'b00, sqa_reg});
            ST_ADD_BB: add_acc = signed'({2'b00, sqb_reg});
            default:   add_acc = '0;
        endcase
    end
    assign add_term = SUM_W'(signed'(prod_reg[32:0]));
    assign add_sum  = add_acc + add_term;

    always_comb begin
        priority if (add_sum > DOT_MAX) begin
            dot_sat = DOT_MAX[ACC_W-1:0];
        end else if (add_sum < DOT_MIN) begin
            dot_sat = DOT_MIN[ACC_W-1:0];
        end else begin
            dot_sat = add_sum[ACC_W-1:0];
        end
        sq_sat = (add_sum > SQ_MAX) ? SQ_MAX[ACC_W-1:0] : add_sum[ACC_W-1:0];
    end

    // Root unit input: sum of squares scaled by 2^20
    assign sqrt_rad   = (state_reg == ST_CHECK) ? {1'b0, sqa_reg, 20'b0}
                                                : {1'b0, sqb_reg, 20'b0};
    assign sqrt_start = ((state_reg == ST_CHECK) && !zero_case)
                     || ((state_reg == ST_SQRT_A) && sqrt_stat.done);
    assign dot_mag    = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
    assign div_start  = (state_reg == ST_DIV_START);

    // Round half away from zero, then clamp to the Q1.15 range
    assign rnd_sum = {1'b0, div_quo} + 1'b1;
    assign mag_rnd = rnd_sum[QUO_W:1];
    always_comb begin
        if (dot_reg[ACC_W-1]) begin
            sim_val = (div_over || (mag_rnd > NEG_LIMIT)) ? 16'sh8000
                                                           : 16'(-mag_rnd);
        end else begin
            sim_val = (div_over || (mag_rnd > POS_LIMIT)) ? 16'sh7FFF
                                                           : mag_rnd[15:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        dot_next      = dot_reg;
        sqa_next      = sqa_reg;
        sqb_next      = sqb_reg;
        prod_next     = prod_reg;
        ra_next       = ra_reg;
        res_sim_next  = res_sim_reg;
        res_zero_next = res_zero_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    a_next     = s_tdata[15:0];
                    b_next     = s_tdata[31:16];
                    last_next  = s_tlast;
                    state_next = ST_MUL_AB;
                end
            end
            ST_MUL_AB: begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_MUL_AA;
            end
            ST_MUL_AA: begin
                prod_next  = mul_p[PROD_W-1:0];
                dot_next   = dot_sat;
                state_next = ST_MUL_BB;
            end
            ST_MUL_BB: begin
                prod_next  = mul_p[PROD_W-1:0];
                sqa_next   = sq_sat;
                state_next = ST_ADD_BB;
            end
            ST_ADD_BB: begin
                sqb_next   = sq_sat;
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                if (zero_case) begin
                    res_sim_next  = '0;
                    res_zero_next = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    state_next    = ST_SQRT_A;
                end
            end
            ST_SQRT_A: begin
                if (sqrt_stat.done) begin
                    ra_next    = sqrt_root;
                    state_next = ST_SQRT_B;
                end
            end
            ST_SQRT_B: begin
                if (sqrt_stat.done) begin
                    prod_next  = mul_p[PROD_W-1:0];
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    res_sim_next  = sim_val;
                    res_zero_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free, then clear the accumulators
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_sim_reg;
                    m_tuser_next  = res_zero_reg;
                    dot_next      = '0;
                    sqa_next      = '0;
                    sqb_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dot_reg      <= '0;
            sqa_reg      <= '0;
            sqb_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dot_reg      <= dot_next;
            sqa_reg      <= sqa_next;
            sqb_reg      <= sqb_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        ra_reg       <= ra_next;
        res_sim_reg  <= res_sim_next;
        res_zero_reg <= res_zero_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    cse_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .status   (sqrt_stat)
    );

    cse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dot_mag),
        .divisor  (prod_reg),
        .quotient (div_quo),
        .over     (div_over),
        .status   (div_stat)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Units sit idle whenever a new word may enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!sqrt_stat.busy && !div_stat.busy))
        else $error("arithmetic unit busy while accepting a word");

    // An accepted word closes the input until the sequencer returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("second word accepted while sequencer busy");

    // A zero-norm result always carries similarity zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'h0000))
        else $error("zero_norm result with non-zero similarity");

    // Emitting a result clears all three accumulators
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free) |=>
            ((dot_reg == '0) && (sqa_reg == '0) && (sqb_reg == '0)))
        else $error("accumulators not cleared after result");

endmodule

>>> bench/cosine_similarity_engine_test.sv
// Self-checking bench for the cosine similarity engine: directed and random vectors.
`timescale 1ns / 1ps

module cosine_similarity_engine_test;

    // Accumulator limits: signed 43-bit dot product, unsigned 43-bit sums of squares
    localparam longint signed   DOT_HI = 64'sh3FF_FFFF_FFFF;
    localparam longint signed   DOT_LO = -DOT_HI - 1;
    localparam longint unsigned SQ_TOP = 64'h7FF_FFFF_FFFF;

    localparam int RANDOM_PAIRS      = 480;
    localparam int LONG_HOLD         = 600;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SETTLE_CYCLES     = 200;

    localparam logic [15:0] CORNER_VALUES [6] =
        '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

    typedef enum int {FLOW_FREE, FLOW_SHORT, FLOW_BURSTY} flow_e;
    typedef enum int {
        STYLE_FULL, STYLE_SMALL, STYLE_CORNER, STYLE_CORRELATED, STYLE_ZERO_A, STYLE_ZERO_B
    } style_e;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               zero_norm;
    } cosine_t;

    // Predicts the cosine word that each vector pair produces and checks the block's words.
    class cosine_predictor;
        longint signed   dot_acc;
        longint unsigned energy_a;
        longint unsigned energy_b;
        cosine_t         expected_cosines[$];
        int              errors;

        function new();
            dot_acc  = 0;
            energy_a = 0;
            energy_b = 0;
            errors   = 0;
        endfunction

        function longint unsigned int_root(longint unsigned x);
            longint unsigned root;
            longint unsigned probe;
            root = 0;
            for (int i = 31; i >= 0; i--) begin
                probe = root | (64'd1 << i);
                if (probe * probe <= x) begin
                    root = probe;
                end
            end
            return root;
        endfunction

        function longint unsigned add_energy(longint unsigned acc, longint unsigned sq);
            longint unsigned total;
            total = acc + sq;
            return (total > SQ_TOP) ? SQ_TOP : total;
        endfunction

        // Roots carry 10 fraction bits; the quotient carries 36 before rounding to Q1.15.
        function logic signed [15:0] cosine_q15();
            longint unsigned root_a;
            longint unsigned root_b;
            longint unsigned mag;
            bit [99:0]       num;
            bit [99:0]       quo;
            bit [99:0]       neg;
            root_a = int_root(energy_a << 20);
            root_b = int_root(energy_b << 20);
            mag    = (dot_acc < 0) ? -dot_acc : dot_acc;
            num    = 100'(mag) << 36;
            quo    = num / 100'(root_a * root_b);
            quo    = (quo + 1) >> 1;
            if (dot_acc < 0) begin
                if (quo > 32768) begin
                    return 16'h8000;
                end
                neg = -quo;
                return neg[15:0];
            end
            return (quo > 32767) ? 16'h7FFF : quo[15:0];
        endfunction

        function void absorb_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
            longint signed pa;
            longint signed pb;
            longint signed sum;
            cosine_t       res;
            pa  = a;
            pb  = b;
            sum = dot_acc + pa * pb;
            if (sum > DOT_HI) begin
                sum = DOT_HI;
            end else if (sum < DOT_LO) begin
                sum = DOT_LO;
            end
            dot_acc  = sum;
            energy_a = add_energy(energy_a, longint'(pa * pa));
            energy_b = add_energy(energy_b, longint'(pb * pb));
            if (!last) begin
                return;
            end
            if (energy_a == 0 || energy_b == 0) begin
                res.similarity = '0;
                res.zero_norm  = 1'b1;
            end else begin
                res.similarity = cosine_q15();
                res.zero_norm  = 1'b0;
            end
            expected_cosines.push_back(res);
            dot_acc  = 0;
            energy_a = 0;
            energy_b = 0;
        endfunction

        function void check_cosine(logic [15:0] similarity, logic zero_norm);
            cosine_t want;
            if (expected_cosines.size() == 0) begin
                $error("cosine word with none expected: similarity %0d, zero_norm %0b",
                       $signed(similarity), zero_norm);
                errors++;
                return;
            end
            want = expected_cosines.pop_front();
            if (similarity !== want.similarity) begin
                $error("similarity: expected %0d, got %0d", want.similarity, $signed(similarity));
                errors++;
            end
            if (zero_norm !== want.zero_norm) begin
                $error("zero_norm: expected %0b, got %0b", want.zero_norm, zero_norm);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // feature_a [15:0], feature_b [31:16]
    logic        s_tlast  = 1'b0;   // last_element
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // similarity [15:0]
    logic [0:0]  m_tuser;           // zero_norm [0]

    cosine_predictor tracker;
    flow_e           flow         = FLOW_FREE;
    bit              hold_request = 1'b0;
    int              quiet_cycles = 0;
    int              pairs_sent   = 0;

    cosine_similarity_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sample both handshakes at the edge: feed accepted pairs to the predictor, check results,
    // and count cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.absorb_pair(s_tdata[15:0], s_tdata[31:16], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_cosine(m_tdata, m_tuser[0]);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("cosine_similarity_engine_test: errors");
        $finish;
    end

    // Receiver: free-flowing, randomly stalled, or held off for a long stretch on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (flow == FLOW_FREE) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(99) < 4) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(40, 8)) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) < 70);
            end
        end
    end

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(99);
        if (flow == FLOW_FREE || roll < 60) begin
            return 0;
        end
        if (roll < 92 || flow == FLOW_SHORT) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // Offer one word and hold it until accepted; then idle for a random gap.
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every expected cosine has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_cosines.size() != 0) @(posedge aclk);
    endtask

    function automatic style_e pick_style();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return STYLE_FULL;
        if (roll < 50) return STYLE_SMALL;
        if (roll < 65) return STYLE_CORNER;
        if (roll < 90) return STYLE_CORRELATED;
        if (roll < 95) return STYLE_ZERO_A;
        return STYLE_ZERO_B;
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(8, 1);
        if (roll < 95) return $urandom_range(32, 9);
        return $urandom_range(100, 33);
    endfunction

    function automatic void pick_pair(input style_e style, output logic [15:0] a,
                                      output logic [15:0] b);
        a = 16'($urandom);
        b = 16'($urandom);
        case (style)
            STYLE_SMALL: begin
                a = 16'($urandom_range(511)) - 16'd256;
                b = 16'($urandom_range(511)) - 16'd256;
            end
            STYLE_CORNER: begin
                a = CORNER_VALUES[$urandom_range(5)];
                b = CORNER_VALUES[$urandom_range(5)];
            end
            STYLE_CORRELATED: begin
                case ($urandom_range(2))
                    0: b = a;
                    1: b = -a;
                    default: b = a + 16'($urandom_range(255)) - 16'd128;
                endcase
            end
            STYLE_ZERO_A: a = '0;
            STYLE_ZERO_B: b = '0;
            default: ;
        endcase
    endfunction

    task automatic send_vector(input style_e style, input int len);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < len; i++) begin
            pick_pair(style, a, b);
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial begin
        int random_end;
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full-scale corners, zero norms, orthogonal and alternating-bit vectors
        flow = FLOW_SHORT;
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);     // cosine clamps at -1
        send_pair(16'h0000, 16'h0000, 1'b1);     // both norms zero
        send_pair(16'h0000, 16'h0005, 1'b0);
        send_pair(16'h0000, 16'hFFF9, 1'b1);     // first vector zero
        send_pair(16'h0003, 16'h0000, 1'b0);
        send_pair(16'h0004, 16'h0000, 1'b1);     // reference vector zero
        send_pair(16'h0001, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0001, 1'b1);     // orthogonal: zero cosine, norms non-zero
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'hFFFF, 1'b0);
        send_pair(16'h0001, 16'h0001, 1'b1);
        send_pair(16'h0001, 16'hFFFF, 1'b1);
        send_pair(16'h0001, 16'h8000, 1'b0);
        send_pair(16'h0002, 16'h0064, 1'b0);
        send_pair(16'h0003, 16'h7FFF, 1'b1);
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b1);
        wait_drained();

        // Hold the receiver off while short vectors keep coming, so the input stalls
        flow = FLOW_FREE;
        hold_request = 1'b1;
        repeat (8) send_vector(pick_style(), $urandom_range(4, 1));
        wait_drained();

        // Random vectors in chunks, each chunk under its own flow, pausing now and then
        random_end = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < random_end) begin
            flow = flow_e'($urandom_range(2));
            repeat (6) send_vector(pick_style(), pick_length());
            if ($urandom_range(3) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_cosines.size() == 0) begin
            $display("cosine_similarity_engine_test: clean");
        end else begin
            $display("cosine_similarity_engine_test: errors");
        end
        $finish;
    end

endmodule
